/* rtl/core/mdhl_pkg.sv */
// ============================================================================
// mdhl_pkg
// Shared types and operation codes for the multiply/divide HI/LO unit.
// ============================================================================
`default_nettype none

package mdhl_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MULT  = 4'd0;
    localparam logic [OP_W-1:0] OP_MULTU = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIVU  = 4'd3;
    localparam logic [OP_W-1:0] OP_MADD  = 4'd4;
    localparam logic [OP_W-1:0] OP_MADDU = 4'd5;
    localparam logic [OP_W-1:0] OP_MSUB  = 4'd6;
    localparam logic [OP_W-1:0] OP_MSUBU = 4'd7;
    localparam logic [OP_W-1:0] OP_MTHI  = 4'd8;
    localparam logic [OP_W-1:0] OP_MTLO  = 4'd9;
    localparam logic [OP_W-1:0] OP_MFHI  = 4'd10;
    localparam logic [OP_W-1:0] OP_MFLO  = 4'd11;

    // Control from the sequencer to the iteration datapath
    typedef struct packed {
        logic load;      // take fresh operand magnitudes
        logic step;      // run one shift-add or shift-subtract step
        logic div_mode;  // 1: restoring divide step, 0: multiply step
    } ctrl_t;

endpackage : mdhl_pkg

`default_nettype wire

/* rtl/core/mdhl_iter.sv */
// ============================================================================
// mdhl_iter
// Radix-2 iteration datapath around one shared 33-bit add/subtract unit.
// ============================================================================
`default_nettype none

module mdhl_iter
    import mdhl_pkg::*;
(
    input  wire logic              clk,
    input  wire ctrl_t             ctrl,
    input  wire logic [WORD_W-1:0] load_a,   // multiplier or dividend magnitude
    input  wire logic [WORD_W-1:0] load_b,   // multiplicand or divisor magnitude
    output logic      [WORD_W-1:0] upper,    // product high / remainder
    output logic      [WORD_W-1:0] lower     // product low / quotient
);

    logic [WORD_W-1:0] upper_reg, upper_next;
    logic [WORD_W-1:0] lower_reg, lower_next;
    logic [WORD_W-1:0] opnd_reg;

    logic [WORD_W:0]   add_a;
    logic [WORD_W:0]   add_b;
    logic [WORD_W+1:0] add_res;
    logic              div_ok;

    // Shared adder: sum for multiply, trial subtract for divide
    always_comb
    begin
        if (ctrl.div_mode)
        begin
            add_a   = {upper_reg, lower_reg[WORD_W-1]};
            add_b   = {1'b0, opnd_reg};
            add_res = {1'b0, add_a} - {1'b0, add_b};
        end
        else
        begin
            add_a   = {1'b0, upper_reg};
            add_b   = lower_reg[0] ? {1'b0, opnd_reg} : '0;
            add_res = {1'b0, add_a} + {1'b0, add_b};
        end
    end

    assign div_ok = ~add_res[WORD_W+1];

    always_comb
    begin
        upper_next = upper_reg;
        lower_next = lower_reg;
        if (ctrl.load)
        begin
            upper_next = '0;
            lower_next = load_a;
        end
        else if (ctrl.step)
        begin
            if (ctrl.div_mode)
            begin
                // keep the difference when it does not borrow
                upper_next = div_ok ? add_res[WORD_W-1:0]
                                    : {upper_reg[WORD_W-2:0], lower_reg[WORD_W-1]};
                lower_next = {lower_reg[WORD_W-2:0], div_ok};
            end
            else
            begin
                // shift the sum right, carry into the top
                upper_next = add_res[WORD_W:1];
                lower_next = {add_res[0], lower_reg[WORD_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        lower_reg <= lower_next;
        if (ctrl.load)
            opnd_reg <= load_b;
    end

    assign upper = upper_reg;
    assign lower = lower_reg;

endmodule : mdhl_iter

`default_nettype wire

/* rtl/core/multiply_divide_hilo_unit.sv */
// ============================================================================
// multiply_divide_hilo_unit
// Multiply/divide unit with a HI/LO pair; sequencer, sign fix and accumulate.
// ============================================================================
// Sequence: multiply and divide words run 32 radix-2 steps of the shared adder,
//   then one sign fix and one commit; accumulate forms add one more 64-bit add
//   before the commit; moves and reads go straight to the commit.
// Flow: one word at a time, taken in the cycle after the previous one reaches
//   the output register; a word waits in S_DONE while that register is full.
// Reset: rst_n clears HI, LO, the sequencer and the output valid flag.
`default_nettype none

module multiply_divide_hilo_unit
    import mdhl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  wire logic [3:0]  s_tuser,   // [3:0] operation
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata    // [31:0] hi_value, [63:32] lo_value,
                                        // [95:64] read_value
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ITER = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int CNT_W = $clog2(WORD_W);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [WORD_W-1:0] hi_reg, lo_reg;
    logic [WORD_W-1:0] res_hi_reg, res_hi_next;
    logic [WORD_W-1:0] res_lo_reg, res_lo_next;
    logic [WORD_W-1:0] rd_reg, rd_next;
    logic              div_reg, div_next;
    logic              acc_reg, acc_next;
    logic              sub_reg, sub_next;
    logic              qneg_reg, qneg_next;   // negate product or quotient
    logic              rneg_reg, rneg_next;   // negate remainder

    logic              m_tvalid_reg;
    logic [95:0]       m_tdata_reg;

    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] opa, opb;
    logic              op_signed;
    logic              accept;
    logic              commit;

    ctrl_t             ctrl;
    logic [WORD_W-1:0] mag_a, mag_b;
    logic [WORD_W-1:0] it_upper, it_lower;

    logic [2*WORD_W-1:0] prod_fix;
    logic [2*WORD_W-1:0] acc_sum;

    assign op     = s_tuser;
    assign opa    = s_tdata[WORD_W-1:0];
    assign opb    = s_tdata[2*WORD_W-1:WORD_W];
    assign accept = s_tvalid && s_tready;
    assign commit = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);

    // signed forms have an even code below the move group
    assign op_signed = (op inside {OP_MULT, OP_DIV, OP_MADD, OP_MSUB});

    // take magnitudes on the way into the iteration registers
    assign mag_a = (op_signed && opa[WORD_W-1]) ? (~opa + 1'b1) : opa;
    assign mag_b = (op_signed && opb[WORD_W-1]) ? (~opb + 1'b1) : opb;

    assign ctrl.load     = accept;
    assign ctrl.step     = (state_reg == S_ITER);
    assign ctrl.div_mode = accept ? (op == OP_DIV || op == OP_DIVU) : div_reg;

    mdhl_iter u_iter
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .load_a (mag_a),
        .load_b (mag_b),
        .upper  (it_upper),
        .lower  (it_lower)
    );

    // sign fix of the 64-bit product
    assign prod_fix = qneg_reg ? (~{it_upper, it_lower} + 1'b1) : {it_upper, it_lower};

    // accumulate the fixed product into the current HI/LO pair
    assign acc_sum = sub_reg ? ({hi_reg, lo_reg} - {res_hi_reg, res_lo_reg})
                             : ({hi_reg, lo_reg} + {res_hi_reg, res_lo_reg});

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        res_hi_next = res_hi_reg;
        res_lo_next = res_lo_reg;
        rd_next     = rd_reg;
        div_next    = div_reg;
        acc_next    = acc_reg;
        sub_next    = sub_reg;
        qneg_next   = qneg_reg;
        rneg_next   = rneg_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next  = '1;
                    rd_next     = '0;
                    res_hi_next = hi_reg;
                    res_lo_next = lo_reg;
                    div_next    = (op == OP_DIV || op == OP_DIVU);
                    acc_next    = (op inside {OP_MADD, OP_MADDU, OP_MSUB, OP_MSUBU});
                    sub_next    = (op == OP_MSUB || op == OP_MSUBU);
                    qneg_next   = op_signed && (opa[WORD_W-1] ^ opb[WORD_W-1]);
                    rneg_next   = op_signed && opa[WORD_W-1];
                    case (op)
                        OP_MULT, OP_MULTU, OP_DIV, OP_DIVU,
                        OP_MADD, OP_MADDU, OP_MSUB, OP_MSUBU:
                            state_next = S_ITER;
                        OP_MTHI:
                        begin
                            res_hi_next = opa;
                            state_next  = S_DONE;
                        end
                        OP_MTLO:
                        begin
                            res_lo_next = opa;
                            state_next  = S_DONE;
                        end
                        OP_MFHI:
                        begin
                            rd_next    = hi_reg;
                            state_next = S_DONE;
                        end
                        OP_MFLO:
                        begin
                            rd_next    = lo_reg;
                            state_next = S_DONE;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            S_ITER:
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                    state_next = S_FIX;
            end

            S_FIX:
            begin
                if (div_reg)
                begin
                    // remainder follows the dividend, quotient the sign product
                    res_hi_next = rneg_reg ? (~it_upper + 1'b1) : it_upper;
                    res_lo_next = qneg_reg ? (~it_lower + 1'b1) : it_lower;
                end
                else
                begin
                    res_hi_next = prod_fix[2*WORD_W-1:WORD_W];
                    res_lo_next = prod_fix[WORD_W-1:0];
                end
                state_next = acc_reg ? S_ACC : S_DONE;
            end

            S_ACC:
            begin
                res_hi_next = acc_sum[2*WORD_W-1:WORD_W];
                res_lo_next = acc_sum[WORD_W-1:0];
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (commit)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            hi_reg       <= '0;
            lo_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit)
            begin
                hi_reg       <= res_hi_reg;
                lo_reg       <= res_lo_reg;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_hi_reg <= res_hi_next;
        res_lo_reg <= res_lo_next;
        rd_reg     <= rd_next;
        div_reg    <= div_next;
        acc_reg    <= acc_next;
        sub_reg    <= sub_next;
        qneg_reg   <= qneg_next;
        rneg_reg   <= rneg_next;
        if (commit)
            m_tdata_reg <= {rd_reg, res_lo_reg, res_hi_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER && count_reg != '0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("iteration counter skipped a step");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second word taken while one is in flight");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the commit state");

    a_hilo_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DONE) |=> ($stable(hi_reg) && $stable(lo_reg)))
        else $error("HI/LO changed before commit");

endmodule : multiply_divide_hilo_unit

`default_nettype wire
